>>> rtl/bcdclk_pkg.sv
// Package: widths, command and register codes, and word types of the BCD clock
`timescale 1ns / 1ps
`default_nettype none
package bcdclk_pkg;

	localparam int ALARM_SLOTS_DEF = 5;
	localparam int SLOT_W          = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 12;
	localparam int TPS_W           = 6;
	localparam int HOLD_W          = 12;
	localparam int HOUR_W          = 5;
	localparam int MIN_W           = 6;

	localparam logic [TPS_W-1:0]  TPS_RESET  = 6'd31;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd1860;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = 12'd4095;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_SET_TIME = 2'd1;
	localparam logic [1:0] CMD_LOAD     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HOLD_TICKS = 1'd1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [HOUR_W-1:0] hour_value;
		logic [MIN_W-1:0]  minute_value;
		logic [SLOT_W-1:0] slot_index;
	} in_word_t;

	typedef struct packed {
		logic [3:0]        sec_units;
		logic [2:0]        sec_tens;
		logic [3:0]        min_units;
		logic [2:0]        min_tens;
		logic [3:0]        hour_units;
		logic [1:0]        hour_tens;
		logic              alarm_fired;
		logic [SLOT_W-1:0] fired_slot;
		logic              hold_cleared;
	} out_word_t;

endpackage
`default_nettype wire

>>> rtl/bcdclk_ifs.sv
// Valid/ready channel interfaces for command words and result words
`timescale 1ns / 1ps
`default_nettype none
interface bcdclk_in_if import bcdclk_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bcdclk_out_if import bcdclk_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bcd_clock_with_alarm_slots.sv
// 24-hour BCD clock with alarm slots, display hold and tick prescaler
// One result word per command word, showing the time after the command. A word
// is taken every cycle unless the result side stalls: it lands in an input
// register, and then one pass of logic updates prescaler, time digits, alarm
// table and hold counter and writes the result register, so throughput is one
// word per cycle while not stalled. All slots are compared in parallel; the
// lowest matching slot fires. Ticks are ignored until slot 0 or 1 is loaded
// with a nonzero time. Write the config port only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
module bcd_clock_with_alarm_slots import bcdclk_pkg::*; #(
	parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	bcdclk_in_if.sink                  item,
	bcdclk_out_if.source               result
);

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
	} alarm_t;

	function automatic logic [2:0] tens_of(input logic [MIN_W-1:0] v);
		logic [2:0] t;
		if (v >= 6'd50) begin
			t = 3'd5;
		end else if (v >= 6'd40) begin
			t = 3'd4;
		end else if (v >= 6'd30) begin
			t = 3'd3;
		end else if (v >= 6'd20) begin
			t = 3'd2;
		end else if (v >= 6'd10) begin
			t = 3'd1;
		end else begin
			t = 3'd0;
		end
		return t;
	endfunction

	function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v, input logic [2:0] t);
		logic [MIN_W-1:0] u;
		u = v - MIN_W'({t, 3'b000}) - MIN_W'({t, 1'b0});
		return u[3:0];
	endfunction

	// config
	logic [TPS_W-1:0]  tps_q;
	logic [HOLD_W-1:0] hold_ticks_q;

	// input register
	logic     vld_s1;
	in_word_t word_s1;

	// clock state
	logic [TPS_W-1:0]  prescale_q;
	logic [3:0]        su_q, mu_q, hu_q;
	logic [2:0]        st_q, mt_q;
	logic [1:0]        ht_q;
	logic              running_q;
	logic              hold_act_q;
	logic [HOLD_W-1:0] hold_cnt_q;
	alarm_t            alarm_q [ALARM_SLOTS];

	// result register
	logic      vld_s2;
	out_word_t word_s2;

	logic adv;

	// next-state values
	logic [TPS_W-1:0]  prescale_d;
	logic [3:0]        su_d, mu_d, hu_d;
	logic [2:0]        st_d, mt_d;
	logic [1:0]        ht_d;
	logic              running_d;
	logic              hold_act_d;
	logic [HOLD_W-1:0] hold_cnt_d;
	logic              fired, cleared;
	logic [SLOT_W-1:0] fslot;
	logic              load_en;
	logic              in_range;

	assign adv          = vld_s1 && (!vld_s2 || result.ready);
	assign item.ready   = !vld_s1 || adv;
	assign result.valid = vld_s2;
	assign result.data  = word_s2;

	always_comb begin
		logic [TPS_W-1:0]  pnext;
		logic [HOLD_W-1:0] cnt_inc;
		logic [HOUR_W-1:0] hbin;
		logic [MIN_W-1:0]  mbin;
		logic [2:0]        mv_t;
		logic [2:0]        hv_t;
		logic              match;

		prescale_d = prescale_q;
		su_d       = su_q;
		st_d       = st_q;
		mu_d       = mu_q;
		mt_d       = mt_q;
		hu_d       = hu_q;
		ht_d       = ht_q;
		running_d  = running_q;
		hold_act_d = hold_act_q;
		hold_cnt_d = hold_cnt_q;
		fired      = 1'b0;
		cleared    = 1'b0;
		fslot      = '0;
		load_en    = 1'b0;
		pnext      = prescale_q + 1'b1;
		cnt_inc    = (hold_cnt_q < HOLD_MAX) ? hold_cnt_q + 1'b1 : hold_cnt_q;
		in_range   = (word_s1.hour_value <= 5'd23) && (word_s1.minute_value <= 6'd59);
		mv_t       = tens_of(word_s1.minute_value);
		hv_t       = tens_of(MIN_W'(word_s1.hour_value));
		hbin       = '0;
		mbin       = '0;
		match      = 1'b0;

		case (word_s1.cmd)
			CMD_SET_TIME: begin
				if (in_range) begin
					ht_d = hv_t[1:0];
					hu_d = units_of(MIN_W'(word_s1.hour_value), hv_t);
					mt_d = mv_t;
					mu_d = units_of(word_s1.minute_value, mv_t);
				end
			end
			CMD_LOAD: begin
				if (in_range && (32'(word_s1.slot_index) < ALARM_SLOTS)) begin
					load_en = 1'b1;
					if ((word_s1.slot_index <= 3'd1) &&
					    ((word_s1.hour_value != '0) || (word_s1.minute_value != '0))) begin
						running_d = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (running_q) begin
					if (pnext >= tps_q) begin
						prescale_d = '0;
						su_d = su_q + 1'b1;
						if (su_d >= 4'd10) begin
							su_d = '0;
							st_d = st_q + 1'b1;
						end
						if (st_d >= 3'd6) begin
							st_d = '0;
							mu_d = mu_q + 1'b1;
						end
						if (mu_d >= 4'd10) begin
							mu_d = '0;
							mt_d = mt_q + 1'b1;
						end
						if (mt_d >= 3'd6) begin
							mt_d = '0;
							hu_d = hu_q + 1'b1;
						end
						if (hu_d >= 4'd10) begin
							hu_d = '0;
							ht_d = ht_q + 1'b1;
						end
						if ((ht_d >= 2'd2) && (hu_d >= 4'd4)) begin
							su_d = '0;
							st_d = '0;
							mu_d = '0;
							mt_d = '0;
							hu_d = '0;
							ht_d = '0;
						end
					end else begin
						prescale_d = pnext;
					end

					hbin = HOUR_W'({ht_d, 3'b000}) + HOUR_W'({ht_d, 1'b0}) + HOUR_W'(hu_d);
					mbin = MIN_W'({mt_d, 3'b000}) + MIN_W'({mt_d, 1'b0}) + MIN_W'(mu_d);

					if (hold_act_q) begin
						hold_cnt_d = cnt_inc;
						if (cnt_inc >= hold_ticks_q) begin
							hold_act_d = 1'b0;
							hold_cnt_d = '0;
							cleared    = 1'b1;
						end
					end else if ((su_d == 4'd0) && (st_d == 3'd0)) begin
						// lowest slot wins: scan from the top down
						for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
							if ((alarm_q[i].hour == hbin) && (alarm_q[i].minute == mbin)) begin
								match = 1'b1;
								fslot = SLOT_W'(i);
							end
						end
						if (match) begin
							fired      = 1'b1;
							hold_act_d = 1'b1;
							hold_cnt_d = '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q        <= TPS_RESET;
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_SECOND:   tps_q        <= cfg_data[TPS_W-1:0];
				REG_DISPLAY_HOLD_TICKS: hold_ticks_q <= cfg_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			word_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			su_q       <= '0;
			st_q       <= '0;
			mu_q       <= '0;
			mt_q       <= '0;
			hu_q       <= '0;
			ht_q       <= '0;
			running_q  <= 1'b0;
			hold_act_q <= 1'b0;
			hold_cnt_q <= '0;
			for (int i = 0; i < ALARM_SLOTS; i++) begin
				alarm_q[i] <= '0;
			end
		end else if (adv) begin
			prescale_q <= prescale_d;
			su_q       <= su_d;
			st_q       <= st_d;
			mu_q       <= mu_d;
			mt_q       <= mt_d;
			hu_q       <= hu_d;
			ht_q       <= ht_d;
			running_q  <= running_d;
			hold_act_q <= hold_act_d;
			hold_cnt_q <= hold_cnt_d;
			for (int i = 0; i < ALARM_SLOTS; i++) begin
				if (load_en && (32'(word_s1.slot_index) == i)) begin
					alarm_q[i] <= '{hour: word_s1.hour_value, minute: word_s1.minute_value};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (result.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2.sec_units    <= su_d;
			word_s2.sec_tens     <= st_d;
			word_s2.min_units    <= mu_d;
			word_s2.min_tens     <= mt_d;
			word_s2.hour_units   <= hu_d;
			word_s2.hour_tens    <= ht_d;
			word_s2.alarm_fired  <= fired;
			word_s2.fired_slot   <= fslot;
			word_s2.hold_cleared <= cleared;
		end
	end

	a_fire_xor_clear: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !(word_s2.alarm_fired && word_s2.hold_cleared))
		else $error("alarm fired and hold cleared in the same word");

	a_held_prescale: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (prescale_q == '0))
		else $error("prescaler moved while clock held");

	a_hold_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!hold_act_q |-> (hold_cnt_q == '0))
		else $error("hold count nonzero with no hold active");

	a_fire_starts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fired) |=> hold_act_q)
		else $error("alarm fired without starting a hold");

endmodule
`default_nettype wire

>>> dv/bcd_clock_checker.sv
// Checker: predicts the BCD clock result word for each command word and compares
`timescale 1ns / 1ps
module bcd_clock_checker import bcdclk_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	bcdclk_in_if                       item,
	bcdclk_out_if                      result,
	output int                         mismatches,
	output int                         in_flight
);

	logic [TPS_W-1:0]  tps;
	logic [HOLD_W-1:0] hold_len;
	logic [TPS_W-1:0]  prescale;
	logic [3:0]        digit [6];
	logic              holding;
	logic [HOLD_W-1:0] hold_cnt;
	logic [HOUR_W-1:0] alarm_hour [ALARM_SLOTS_DEF];
	logic [MIN_W-1:0]  alarm_min [ALARM_SLOTS_DEF];
	logic              running;
	out_word_t         display_q [$];
	int                words_in;
	int                words_out;

	assign in_flight = words_in - words_out;

	function void step_second();
		digit[0]++;
		if (digit[0] >= 10) begin digit[0] = 0; digit[1]++; end
		if (digit[1] >= 6) begin digit[1] = 0; digit[2]++; end
		if (digit[2] >= 10) begin digit[2] = 0; digit[3]++; end
		if (digit[3] >= 6) begin digit[3] = 0; digit[4]++; end
		if (digit[4] >= 10) begin digit[4] = 0; digit[5]++; end
		if (digit[5] >= 2 && digit[4] >= 4)
			foreach (digit[i]) digit[i] = 0;
	endfunction

	function out_word_t next_display(in_word_t w);
		out_word_t        r;
		logic [TPS_W-1:0] nxt;
		int               h;
		int               mn;
		bit               ok;
		r = '0;
		ok = (w.hour_value <= 23) && (w.minute_value <= 59);
		case (w.cmd)
			CMD_SET_TIME: begin
				if (ok) begin
					digit[5] = w.hour_value / 10;
					digit[4] = w.hour_value % 10;
					digit[3] = w.minute_value / 10;
					digit[2] = w.minute_value % 10;
				end
			end
			CMD_LOAD: begin
				if (ok && w.slot_index < ALARM_SLOTS_DEF) begin
					alarm_hour[w.slot_index] = w.hour_value;
					alarm_min[w.slot_index] = w.minute_value;
					if (w.slot_index <= 1 && (w.hour_value != 0 || w.minute_value != 0))
						running = 1'b1;
				end
			end
			CMD_TICK: begin
				if (running) begin
					nxt = prescale + 1'b1;
					if (nxt >= tps) begin
						prescale = '0;
						step_second();
					end else begin
						prescale = nxt;
					end
					if (holding) begin
						if (hold_cnt != HOLD_MAX)
							hold_cnt++;
						if (hold_cnt >= hold_len) begin
							holding = 1'b0;
							hold_cnt = '0;
							r.hold_cleared = 1'b1;
						end
					end else if (digit[0] == 0 && digit[1] == 0) begin
						h = digit[5] * 10 + digit[4];
						mn = digit[3] * 10 + digit[2];
						// lowest matching slot wins
						for (int s = 0; s < ALARM_SLOTS_DEF && !r.alarm_fired; s++) begin
							if (alarm_hour[s] == h && alarm_min[s] == mn) begin
								r.alarm_fired = 1'b1;
								r.fired_slot = s;
								holding = 1'b1;
								hold_cnt = '0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.sec_units = digit[0];
		r.sec_tens = digit[1][2:0];
		r.min_units = digit[2];
		r.min_tens = digit[3][2:0];
		r.hour_units = digit[4];
		r.hour_tens = digit[5][1:0];
		return r;
	endfunction

	task report(string what, out_word_t want, out_word_t got, bit have_want);
		mismatches++;
		if (mismatches <= 10) begin
			if (have_want)
				$display("%0t %s: expected %0d%0d:%0d%0d:%0d%0d fired %0b slot %0d cleared %0b",
					$realtime, what, want.hour_tens, want.hour_units, want.min_tens,
					want.min_units, want.sec_tens, want.sec_units, want.alarm_fired,
					want.fired_slot, want.hold_cleared);
			$display("%0t %s: actual   %0d%0d:%0d%0d:%0d%0d fired %0b slot %0d cleared %0b",
				$realtime, what, got.hour_tens, got.hour_units, got.min_tens, got.min_units,
				got.sec_tens, got.sec_units, got.alarm_fired, got.fired_slot, got.hold_cleared);
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			tps = TPS_RESET;
			hold_len = HOLD_RESET;
			prescale = '0;
			foreach (digit[i]) digit[i] = '0;
			holding = 1'b0;
			hold_cnt = '0;
			foreach (alarm_hour[i]) begin
				alarm_hour[i] = '0;
				alarm_min[i] = '0;
			end
			running = 1'b0;
			display_q.delete();
			words_in <= 0;
			words_out <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TICKS_PER_SECOND: tps = cfg_data[TPS_W-1:0];
					REG_DISPLAY_HOLD_TICKS: hold_len = cfg_data[HOLD_W-1:0];
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				words_out <= words_out + 1;
				if (display_q.size() == 0) begin
					report("unexpected word", '0, result.data, 1'b0);
				end else begin
					want = display_q.pop_front();
					if (result.data !== want)
						report("mismatch", want, result.data, 1'b1);
				end
			end
			if (item.valid && item.ready) begin
				display_q.push_back(next_display(item.data));
				words_in <= words_in + 1;
			end
		end
	end

endmodule

>>> dv/bcd_clock_with_alarm_slots_tb.sv
// Testbench top: clock, reset, command stimulus, register phases and verdict
`timescale 1ns / 1ps
module bcd_clock_with_alarm_slots_tb;
	import bcdclk_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    in_flight;
	int                    idle_pct = 0;
	int                    rdy_hold = 0;
	int                    effective = 0;
	int                    cur_tps = TPS_RESET;

	bcdclk_in_if  item_ch ();
	bcdclk_out_if result_ch ();

	bcd_clock_with_alarm_slots DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	bcd_clock_checker display_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (item_ch),
		.result     (result_ch),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (rdy_hold == 0 && $urandom_range(0, 99) < idle_pct)
			rdy_hold = $urandom_range(1, 14);
		if (rdy_hold > 0) begin
			result_ch.ready <= 1'b0;
			rdy_hold--;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task send_word(logic [1:0] c, int h, int m, int s);
		in_word_t w;
		w.cmd = c;
		w.hour_value = h[HOUR_W-1:0];
		w.minute_value = m[MIN_W-1:0];
		w.slot_index = s[SLOT_W-1:0];
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_ch.data <= w;
		item_ch.valid <= 1'b1;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (w.cmd == CMD_TICK || (w.hour_value <= 23 && w.minute_value <= 59 &&
			(w.cmd == CMD_SET_TIME || (w.cmd == CMD_LOAD && w.slot_index < ALARM_SLOTS_DEF))))
			effective++;
	endtask

	task drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task set_rates(int tps, int hold);
		cfg_we <= 1'b1;
		cfg_index <= REG_TICKS_PER_SECOND;
		cfg_data <= CFG_DATA_W'(tps);
		@(posedge clk);
		cfg_index <= REG_DISPLAY_HOLD_TICKS;
		cfg_data <= CFG_DATA_W'(hold);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_tps = tps;
	endtask

	// alarm one minute ahead of the set time, then up to 100 ticks toward the minute boundary
	task alarm_run();
		int h;
		int m;
		int ph;
		int pm;
		int te;
		int n;
		h = $urandom_range(0, 23);
		m = $urandom_range(0, 59);
		if ($urandom_range(0, 4) == 0) begin
			h = 0;
			m = 0;
		end
		ph = h;
		pm = m - 1;
		if (pm < 0) begin
			pm = 59;
			ph = (h == 0) ? 23 : h - 1;
		end
		send_word(CMD_LOAD, h, m, $urandom_range(0, ALARM_SLOTS_DEF - 1));
		send_word(CMD_SET_TIME, ph, pm, $urandom_range(0, 7));
		te = (cur_tps == 0) ? 1 : cur_tps;
		n = 60 * te + $urandom_range(0, 10 * te);
		if (n > 100)
			n = 100;
		repeat (n)
			send_word(CMD_TICK, $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 7));
	endtask

	initial begin
		int start;
		int tps;
		int hold;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		send_word(CMD_TICK, 5, 5, 1);
		send_word(CMD_UNUSED, 31, 63, 7);
		send_word(CMD_SET_TIME, 24, 0, 0);
		send_word(CMD_SET_TIME, 12, 60, 0);
		send_word(CMD_SET_TIME, 31, 63, 7);
		send_word(CMD_LOAD, 10, 10, 5);
		send_word(CMD_LOAD, 10, 10, 7);
		send_word(CMD_LOAD, 24, 0, 2);
		send_word(CMD_LOAD, 0, 0, 0);
		send_word(CMD_LOAD, 23, 59, 2);
		send_word(CMD_TICK, 0, 0, 0);
		send_word(CMD_SET_TIME, 23, 59, 0);
		send_word(CMD_SET_TIME, 0, 0, 0);
		send_word(CMD_SET_TIME, 23, 59, 0);
		send_word(CMD_LOAD, 23, 59, 1);
		send_word(CMD_TICK, 0, 0, 0);
		send_word(CMD_TICK, 31, 63, 7);
		send_word(CMD_LOAD, 0, 0, 4);
		send_word(CMD_LOAD, 12, 34, 3);
		send_word(CMD_SET_TIME, 12, 34, 0);
		send_word(CMD_TICK, 0, 0, 0);
		send_word(CMD_LOAD, 0, 0, 1);

		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: begin tps = 63; hold = 4095; end
				1: begin tps = 5; hold = 3; end
				2: begin tps = 0; hold = 0; end
				3: begin tps = 1; hold = 1; end
				7: begin tps = 1; hold = 10; end
				default: begin
					tps = $urandom_range(1, 3);
					hold = $urandom_range(0, 60);
				end
			endcase
			set_rates(tps, hold);
			if (p == 7)
				idle_pct = 0;
			else
				idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
			start = effective;
			while (effective - start < 40) begin
				if ($urandom_range(0, 9) < 6) begin
					alarm_run();
				end else begin
					repeat ($urandom_range(1, 4))
						send_word(2'($urandom_range(0, 3)), $urandom_range(0, 31),
							$urandom_range(0, 63), $urandom_range(0, 7));
				end
			end
		end

		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
